>>> rtl/dbt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dbt_pkg
// Shared types and constants for the event-coalescing timer.
// ----------------------------------------------------------------------------
package dbt_pkg;

   // Widths of the item fields and the configuration registers.
   localparam int unsigned CMD_W     = 2;
   localparam int unsigned PAYLOAD_W = 32;
   localparam int unsigned REG_W     = 16;

   // Reset values of the delay registers.
   localparam logic [REG_W-1:0] MIN_DELAY_RST = 16'd250;
   localparam logic [REG_W-1:0] MAX_DELAY_RST = 16'd0;

   // Configuration register indexes.
   localparam logic CSR_MIN_DELAY = 1'b0;
   localparam logic CSR_MAX_DELAY = 1'b1;

   // Commands carried by an input item.
   typedef enum logic [CMD_W-1:0] {
      CMD_TRIGGER = 2'd0,   // trigger, keep the held value
      CMD_LOAD    = 2'd1,   // latch the payload, then trigger
      CMD_CANCEL  = 2'd2,   // stop both countdowns
      CMD_TICK    = 2'd3    // one timer tick
   } cmd_type;

   // One result item.
   typedef struct packed {
      logic                 pending;
      logic                 fired;
      logic [PAYLOAD_W-1:0] value;
   } rsp_type;

endpackage
`default_nettype wire

>>> rtl/debounce_with_max_latency_timer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// debounce_with_max_latency_timer
// Event-coalescing timer with a minimum idle time and a maximum latency.
// ----------------------------------------------------------------------------
// Every input item yields exactly one result item. Triggers restart an idle
// countdown of min_delay ticks and, when max_delay is nonzero and no latency
// countdown runs yet, start one of max_delay ticks; tick items count both
// down, and the block fires with the last latched payload when either one
// expires. The block takes one item per clock cycle while the result side
// is not stalled. An accepted item waits in the input register, then the
// combinational counter update loads its result into the result register.
// A stalled result holds the result register, and the input register takes
// items while it is empty or the result register is free or being emptied.
// Delay registers take effect at the next trigger.
module debounce_with_max_latency_timer #(
   parameter int unsigned DELAY_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // Input items.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // [31:0] payload
   input  wire logic [1:0]  req_tuser,   // [1:0] cmd
   // Result items.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // [31:0] value
   output logic [1:0]       rsp_tuser,   // [0] fired, [1] pending
   // Configuration writes.
   input  wire logic        csr_we,
   input  wire logic        csr_addr,
   input  wire logic [15:0] csr_wdata
);

   logic                          in_valid_ff;
   dbt_pkg::cmd_type              in_cmd_ff;
   logic [dbt_pkg::PAYLOAD_W-1:0] in_payload_ff;
   logic                          out_valid_ff;
   dbt_pkg::rsp_type              out_rsp_ff;
   logic [dbt_pkg::REG_W-1:0]     min_delay_ff;
   logic [dbt_pkg::REG_W-1:0]     max_delay_ff;

   logic                          out_free;
   logic                          advance;
   dbt_pkg::rsp_type              core_rsp;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         min_delay_ff <= dbt_pkg::MIN_DELAY_RST;
         max_delay_ff <= dbt_pkg::MAX_DELAY_RST;
      end else if (csr_we) begin
         case (csr_addr)
            dbt_pkg::CSR_MIN_DELAY: min_delay_ff <= csr_wdata;
            dbt_pkg::CSR_MAX_DELAY: max_delay_ff <= csr_wdata;
            default: begin
               min_delay_ff <= min_delay_ff;
            end
         endcase
      end
   end

   // Handshake: the input register moves on whenever the result register
   // is empty or its item is being taken.
   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_cmd_ff     <= dbt_pkg::cmd_type'(req_tuser);
         in_payload_ff <= req_tdata;
      end
   end

   // Countdown state and item update.
   dbt_core #(
      .DELAY_BITS (DELAY_BITS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .cmd       (in_cmd_ff),
      .payload   (in_payload_ff),
      .min_delay (min_delay_ff),
      .max_delay (max_delay_ff),
      .rsp       (core_rsp)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= advance;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_rsp_ff <= core_rsp;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_rsp_ff.value;
   assign rsp_tuser  = {out_rsp_ff.pending, out_rsp_ff.fired};

endmodule
`default_nettype wire

>>> rtl/dbt_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dbt_core
// Countdown state of the timer and the single-pass update for one item.
// ----------------------------------------------------------------------------
module dbt_core #(
   parameter int unsigned DELAY_BITS = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                step,
   input  wire dbt_pkg::cmd_type                    cmd,
   input  wire logic [dbt_pkg::PAYLOAD_W-1:0]       payload,
   input  wire logic [dbt_pkg::REG_W-1:0]           min_delay,
   input  wire logic [dbt_pkg::REG_W-1:0]           max_delay,
   output dbt_pkg::rsp_type                         rsp
);

   logic [DELAY_BITS-1:0]         idle_cnt_ff, idle_cnt_in;
   logic                          idle_run_ff, idle_run_in;
   logic [DELAY_BITS-1:0]         lat_cnt_ff, lat_cnt_in;
   logic                          lat_run_ff, lat_run_in;
   logic [dbt_pkg::PAYLOAD_W-1:0] held_ff, held_in;

   logic [DELAY_BITS-1:0] mn;
   logic [DELAY_BITS-1:0] mx;
   logic                  fire;
   logic                  idle_exp;
   logic                  lat_exp;

   // Delays are loaded as wide as the counters.
   assign mn = DELAY_BITS'(min_delay);
   assign mx = DELAY_BITS'(max_delay);

   // Next state and result for the item in the input register.
   always_comb begin
      idle_cnt_in = idle_cnt_ff;
      idle_run_in = idle_run_ff;
      lat_cnt_in  = lat_cnt_ff;
      lat_run_in  = lat_run_ff;
      held_in     = held_ff;
      fire        = 1'b0;
      idle_exp    = 1'b0;
      lat_exp     = 1'b0;
      case (cmd)
         dbt_pkg::CMD_TRIGGER, dbt_pkg::CMD_LOAD: begin
            if (cmd == dbt_pkg::CMD_LOAD) begin
               held_in = payload;
            end
            // The latency countdown starts only if it is not already running.
            if ((mx != '0) && !lat_run_ff) begin
               lat_cnt_in = mx;
               lat_run_in = 1'b1;
            end
            idle_cnt_in = mn;
            idle_run_in = (mn != '0);
            // With both delays disabled the trigger passes straight through.
            fire = (mn == '0) && (mx == '0);
         end
         dbt_pkg::CMD_CANCEL: begin
            idle_cnt_in = '0;
            idle_run_in = 1'b0;
            lat_cnt_in  = '0;
            lat_run_in  = 1'b0;
         end
         dbt_pkg::CMD_TICK: begin
            // A running count of one or zero expires on this tick.
            if (idle_run_ff) begin
               if (idle_cnt_ff <= DELAY_BITS'(1)) begin
                  idle_cnt_in = '0;
                  idle_exp    = 1'b1;
               end else begin
                  idle_cnt_in = idle_cnt_ff - DELAY_BITS'(1);
               end
            end
            if (lat_run_ff) begin
               if (lat_cnt_ff <= DELAY_BITS'(1)) begin
                  lat_cnt_in = '0;
                  lat_exp    = 1'b1;
               end else begin
                  lat_cnt_in = lat_cnt_ff - DELAY_BITS'(1);
               end
            end
            fire = idle_exp || lat_exp;
         end
         default: begin
            fire = 1'b0;
         end
      endcase
      // Firing stops both countdowns.
      if (fire) begin
         idle_cnt_in = '0;
         idle_run_in = 1'b0;
         lat_cnt_in  = '0;
         lat_run_in  = 1'b0;
      end
   end

   assign rsp.fired   = fire;
   assign rsp.value   = fire ? held_in : '0;
   assign rsp.pending = idle_run_in || lat_run_in;

   // State registers advance once per processed item.
   always_ff @(posedge clock) begin
      if (reset) begin
         idle_cnt_ff <= '0;
         idle_run_ff <= 1'b0;
         lat_cnt_ff  <= '0;
         lat_run_ff  <= 1'b0;
         held_ff     <= '0;
      end else if (step) begin
         idle_cnt_ff <= idle_cnt_in;
         idle_run_ff <= idle_run_in;
         lat_cnt_ff  <= lat_cnt_in;
         lat_run_ff  <= lat_run_in;
         held_ff     <= held_in;
      end
   end

endmodule
`default_nettype wire

>>> tb/sv/dbt_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dbt_checker
// Result predictor and scoreboard for the event-coalescing timer.
// ----------------------------------------------------------------------------
// Watches the item, result and register channels of the timer. Each accepted
// item runs through a local model of the two countdowns, and the predicted
// result is queued. Each accepted result is checked field by field against
// the oldest prediction. Mismatches are counted and handed to the top.
module dbt_checker
   import dbt_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [31:0] req_tdata,
   input  wire logic [1:0]  req_tuser,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [31:0] rsp_tdata,
   input  wire logic [1:0]  rsp_tuser,
   input  wire logic        csr_we,
   input  wire logic        csr_addr,
   input  wire logic [15:0] csr_wdata,
   output int               error_count,
   output int               results_owed
);

   // Delay settings as last written.
   logic [REG_W-1:0]     idle_setting;
   logic [REG_W-1:0]     latency_setting;

   // Local copy of the countdowns and the held payload.
   logic [REG_W-1:0]     idle_left;
   logic                 idle_on;
   logic [REG_W-1:0]     latency_left;
   logic                 latency_on;
   logic [PAYLOAD_W-1:0] held_payload;

   // Results predicted but not yet delivered, oldest first.
   rsp_type              results_due[$];

   initial begin
      error_count  = 0;
      results_owed = 0;
   end

   // Advances the local timer by one item and returns the result it yields.
   function automatic rsp_type timer_step(input cmd_type cmd,
                                          input logic [PAYLOAD_W-1:0] payload);
      rsp_type outcome;
      logic    fire;
      logic    idle_expired;
      logic    latency_expired;
      fire            = 1'b0;
      idle_expired    = 1'b0;
      latency_expired = 1'b0;
      case (cmd)
         CMD_TRIGGER, CMD_LOAD: begin
            if (cmd == CMD_LOAD) held_payload = payload;
            // The latency countdown only starts if it is not yet running.
            if (latency_setting != '0 && !latency_on) begin
               latency_left = latency_setting;
               latency_on   = 1'b1;
            end
            // The idle countdown restarts on every trigger.
            idle_left = idle_setting;
            idle_on   = (idle_setting != '0);
            // With both delays off the trigger passes straight through.
            fire = (idle_setting == '0) && (latency_setting == '0);
         end
         CMD_CANCEL: begin
            idle_on      = 1'b0;
            latency_on   = 1'b0;
            idle_left    = '0;
            latency_left = '0;
         end
         default: begin
            // A tick counts down every running countdown; one at or below one
            // expires.
            if (idle_on) begin
               if (idle_left <= 1) begin
                  idle_left    = '0;
                  idle_expired = 1'b1;
               end else begin
                  idle_left = idle_left - 1'b1;
               end
            end
            if (latency_on) begin
               if (latency_left <= 1) begin
                  latency_left    = '0;
                  latency_expired = 1'b1;
               end else begin
                  latency_left = latency_left - 1'b1;
               end
            end
            fire = idle_expired || latency_expired;
         end
      endcase
      // Firing stops both countdowns, even when both expire on one tick.
      if (fire) begin
         idle_on      = 1'b0;
         latency_on   = 1'b0;
         idle_left    = '0;
         latency_left = '0;
      end
      outcome.fired   = fire;
      outcome.value   = fire ? held_payload : '0;
      outcome.pending = idle_on || latency_on;
      return outcome;
   endfunction

   always @(posedge clock) begin
      rsp_type due;
      if (reset) begin
         idle_setting    = MIN_DELAY_RST;
         latency_setting = MAX_DELAY_RST;
         idle_left       = '0;
         idle_on         = 1'b0;
         latency_left    = '0;
         latency_on      = 1'b0;
         held_payload    = '0;
         results_due.delete();
      end else begin
         // Check a delivered result against the oldest prediction.
         if (rsp_tvalid && rsp_tready) begin
            if (results_due.size() == 0) begin
               error_count++;
               $error("result item with no item waiting for it: value %h, flags %b",
                      rsp_tdata, rsp_tuser);
            end else begin
               due = results_due.pop_front();
               if (rsp_tuser[0] !== due.fired) begin
                  error_count++;
                  $error("fired: expected %0b, actual %0b", due.fired, rsp_tuser[0]);
               end
               if (rsp_tdata !== due.value) begin
                  error_count++;
                  $error("value: expected %h, actual %h", due.value, rsp_tdata);
               end
               if (rsp_tuser[1] !== due.pending) begin
                  error_count++;
                  $error("pending: expected %0b, actual %0b", due.pending, rsp_tuser[1]);
               end
            end
         end
         // Predict the result of an accepted item.
         if (req_tvalid && req_tready) begin
            results_due.push_back(timer_step(cmd_type'(req_tuser), req_tdata));
         end
         // Register writes apply from the next item on.
         if (csr_we) begin
            if (csr_addr == CSR_MIN_DELAY) begin
               idle_setting = csr_wdata;
            end else if (csr_addr == CSR_MAX_DELAY) begin
               latency_setting = csr_wdata;
            end
         end
      end
      results_owed = results_due.size();
   end

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the event-coalescing timer.
// ----------------------------------------------------------------------------
// Runs a directed sequence over the pass-through, idle-only, latency-only and
// combined settings, then random phases of triggers, loads, cancels and ticks
// under varying delay settings. Both channels see random idle bursts except
// in the closing stretch. A separate checker predicts and compares results.
module tb_top;
   import dbt_pkg::*;

   localparam int DIRECTED_ITEMS = 25;
   localparam int RANDOM_ITEMS   = 350;
   localparam int CALM_ITEMS     = 60;
   localparam int DRAIN_CYCLES   = 4;
   localparam int WATCHDOG_LIMIT = 2000;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;
   logic [1:0]  req_tuser  = CMD_TRIGGER;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_we     = 1'b0;
   logic        csr_addr   = CSR_MIN_DELAY;
   logic [15:0] csr_wdata  = '0;

   int          error_count;
   int          results_owed;
   int          items_sent      = 0;
   int          stall_cycles    = 0;
   logic        calm            = 1'b0;
   logic        sender_gaps     = 1'b1;
   logic        receiver_stalls = 1'b1;

   // 50 MHz clock.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   debounce_with_max_latency_timer DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // [31:0] payload
      .req_tuser  (req_tuser),   // [1:0] cmd
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // [31:0] value
      .rsp_tuser  (rsp_tuser),   // [0] fired, [1] pending
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   dbt_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .csr_we       (csr_we),
      .csr_addr     (csr_addr),
      .csr_wdata    (csr_wdata),
      .error_count  (error_count),
      .results_owed (results_owed)
   );

   // Result side back-pressure: random stall bursts unless stalls are off.
   always begin
      @(negedge clock);
      if (!calm && receiver_stalls && $urandom_range(0, 3) == 0) begin
         rsp_tready <= 1'b0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
      end
      rsp_tready <= 1'b1;
   end

   // End the run if no channel moves for too long.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
      end
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Offers one item, maybe after an idle burst, and returns once it is taken.
   // Entered and left at a falling edge.
   task automatic send_item(input cmd_type cmd, input logic [31:0] payload);
      if (!calm && sender_gaps && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= payload;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
      @(negedge clock);
   endtask

   // Lets the timer drain, then writes both delay registers.
   task automatic set_delays(input logic [REG_W-1:0] idle_ticks,
                             input logic [REG_W-1:0] latency_ticks);
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (results_owed != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= CSR_MIN_DELAY;
      csr_wdata <= idle_ticks;
      @(negedge clock);
      csr_addr  <= CSR_MAX_DELAY;
      csr_wdata <= latency_ticks;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   initial begin
      int      pick;
      int      burst;
      cmd_type cmd;

      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // Reset settings: long idle delay, no latency limit; the load starts the idle
      // countdown, and the ticks and cancels that follow must not fire.
      send_item(CMD_LOAD, 32'hFFFF_FFFF);
      send_item(CMD_TICK, 32'h0000_0000);
      send_item(CMD_CANCEL, 32'h0000_0000);
      send_item(CMD_TICK, 32'hFFFF_FFFF);
      send_item(CMD_CANCEL, 32'hFFFF_FFFF);

      // Both delays off: every trigger fires at once.
      set_delays(16'd0, 16'd0);
      send_item(CMD_LOAD, 32'h0000_0000);
      send_item(CMD_TRIGGER, 32'hFFFF_FFFF);
      send_item(CMD_LOAD, 32'hA5A5_A5A5);
      send_item(CMD_TICK, 32'h5A5A_5A5A);

      // Equal delays: both countdowns expire on the same tick, one firing.
      set_delays(16'd2, 16'd2);
      send_item(CMD_LOAD, 32'h5A5A_5A5A);
      send_item(CMD_TICK, 32'h0000_0000);
      send_item(CMD_TICK, 32'h0000_0000);

      // Idle countdown only: a second trigger restarts it.
      set_delays(16'd3, 16'd0);
      send_item(CMD_TRIGGER, 32'h1111_1111);
      send_item(CMD_TICK, 32'h0000_0000);
      send_item(CMD_TRIGGER, 32'h2222_2222);
      send_item(CMD_TICK, 32'h0000_0000);
      send_item(CMD_TICK, 32'h0000_0000);
      send_item(CMD_TICK, 32'h0000_0000);

      // Latency countdown only: a second trigger does not restart it.
      set_delays(16'd0, 16'd2);
      send_item(CMD_LOAD, 32'h1234_5678);
      send_item(CMD_TRIGGER, 32'h0000_0000);
      send_item(CMD_TICK, 32'h0000_0000);
      send_item(CMD_TICK, 32'h0000_0000);

      // Largest delays.
      set_delays(16'hFFFF, 16'hFFFF);
      send_item(CMD_LOAD, 32'hFFFF_FFFF);
      send_item(CMD_TICK, 32'h0000_0000);
      send_item(CMD_CANCEL, 32'h0000_0000);

      // Random phases. Countdowns left running carry over into the next
      // setting, which only applies from the next trigger on.
      while (items_sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
         calm            = (items_sent >= DIRECTED_ITEMS + RANDOM_ITEMS - CALM_ITEMS);
         sender_gaps     = ($urandom_range(0, 9) < 7);
         receiver_stalls = ($urandom_range(0, 9) < 7);
         case ($urandom_range(0, 9))
            0:       set_delays(16'd0, 16'd0);
            1:       set_delays(16'hFFFF, REG_W'($urandom_range(1, 8)));
            2:       set_delays(REG_W'($urandom_range(1, 8)), 16'hFFFF);
            3:       set_delays(16'd0, REG_W'($urandom_range(1, 10)));
            4:       set_delays(REG_W'($urandom_range(1, 10)), 16'd0);
            default: set_delays(REG_W'($urandom_range(1, 6)),
                                REG_W'($urandom_range(0, 12)));
         endcase
         // Mostly ticks, so that countdowns regularly run out.
         burst = $urandom_range(20, 50);
         repeat (burst) begin
            pick = $urandom_range(0, 19);
            if (pick < 11) begin
               cmd = CMD_TICK;
            end else if (pick < 15) begin
               cmd = CMD_LOAD;
            end else if (pick < 18) begin
               cmd = CMD_TRIGGER;
            end else begin
               cmd = CMD_CANCEL;
            end
            send_item(cmd, $urandom());
         end
      end

      // Drain and give the verdict.
      calm = 1'b1;
      req_tvalid <= 1'b0;
      while (results_owed != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
